[hdl/swas_pkg.sv]
package swas_pkg;

  localparam int WINDOW_SLOTS_DEF = 8;
  localparam int MAX_PAYLOAD_DEF  = 56;

  localparam int LEN_W     = 6;
  localparam int SEQ_W     = 32;
  localparam int HDR_BYTES = 8;
  localparam int HDR_IDX_W = 3;

  localparam logic [LEN_W-1:0] PAYLOAD_LENGTH_RST = 6'd56;
  localparam logic [7:0]       SYNC_FF            = 8'hFF;
  localparam logic [7:0]       SYNC_55            = 8'h55;

  typedef enum logic [1:0] {
    OP_DATA,
    OP_FLUSH,
    OP_ACK,
    OP_TIMEOUT
  } op_t;

  typedef enum logic [1:0] {
    KIND_NEW,
    KIND_RETX,
    KIND_REFUSED
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_META,
    ST_HDR,
    ST_PAY,
    ST_SLIDE
  } state_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  data_byte;
    logic [31:0] ack_number;
    logic        ack_is_nak;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    kind_t      out_kind;
  } result_t;

  // per-slot segment info kept in the slot memory
  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] len;
  } meta_t;

  typedef struct packed {
    logic busy;
    logic window_full;
  } status_t;

endpackage

[hdl/sliding_window_arq_sender_top.sv]
// Data bytes that do not close a segment leave the block idle for the next item while
// the output register has room; a refused byte gives its status transfer in the cycle
// after acceptance. A closing byte or a flush of a non-empty segment sends 8 header
// bytes, then the payload bytes, one per push; a retransmit first reads the slot memory.
// An ack that is neither a NAK nor stale reads the slot memory once per released
// segment, and once more when a segment stays outstanding. Reset clears control state,
// restores payload_length to 56 and does not clear the memories.
module sliding_window_arq_sender_top #(
  parameter int WINDOW_SLOTS = swas_pkg::WINDOW_SLOTS_DEF,
  parameter int MAX_PAYLOAD  = swas_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [swas_pkg::LEN_W-1:0] cfg_data,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  swas_pkg::item_t            item,
  output logic                       result_valid,
  input  logic                       result_stall,
  output swas_pkg::result_t          result
);

  import swas_pkg::*;

  localparam int SLOT_W = $clog2(WINDOW_SLOTS);
  localparam int ADDR_W = $clog2(WINDOW_SLOTS * MAX_PAYLOAD);

  logic              out_free;
  logic              push;
  result_t           push_data;
  status_t           status;
  logic              store_we;
  logic [ADDR_W-1:0] store_waddr;
  logic [7:0]        store_wdata;
  logic              store_re;
  logic [ADDR_W-1:0] store_raddr;
  logic [7:0]        store_rdata;
  logic              meta_we;
  logic [SLOT_W-1:0] meta_waddr;
  meta_t             meta_wdata;
  logic              meta_re;
  logic [SLOT_W-1:0] meta_raddr;
  meta_t             meta_rdata;

  assign cfg_ready = 1'b1;

  swas_ram #(
    .WIDTH(8),
    .DEPTH(WINDOW_SLOTS * MAX_PAYLOAD)
  ) u_store (
    .clk  (clk),
    .we   (store_we),
    .waddr(store_waddr),
    .wdata(store_wdata),
    .re   (store_re),
    .raddr(store_raddr),
    .rdata(store_rdata)
  );

  swas_ram #(
    .WIDTH($bits(meta_t)),
    .DEPTH(WINDOW_SLOTS)
  ) u_meta (
    .clk  (clk),
    .we   (meta_we),
    .waddr(meta_waddr),
    .wdata(meta_wdata),
    .re   (meta_re),
    .raddr(meta_raddr),
    .rdata(meta_rdata)
  );

  swas_ctrl #(
    .WINDOW_SLOTS(WINDOW_SLOTS),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .item_stall (item_stall),
    .out_free   (out_free),
    .push       (push),
    .push_data  (push_data),
    .status     (status),
    .store_we   (store_we),
    .store_waddr(store_waddr),
    .store_wdata(store_wdata),
    .store_re   (store_re),
    .store_raddr(store_raddr),
    .store_rdata(store_rdata),
    .meta_we    (meta_we),
    .meta_waddr (meta_waddr),
    .meta_wdata (meta_wdata),
    .meta_re    (meta_re),
    .meta_raddr (meta_raddr),
    .meta_rdata (meta_rdata)
  );

  swas_outreg u_outreg (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .stall    (result_stall),
    .valid    (result_valid),
    .data     (result),
    .free     (out_free)
  );

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    push |-> out_free)
    else $error("result pushed into an occupied output register");

  a_idle_push_is_status: assert property (@(posedge clk) disable iff (rst)
    (push && !status.busy) |-> (push_data.out_kind == KIND_REFUSED))
    else $error("segment byte pushed while the sequencer is idle");

  a_refused_status: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && item.op == OP_DATA && status.window_full)
      |=> (result_valid && result.out_kind == KIND_REFUSED && result.out_last))
    else $error("data byte in a full window gave no refused status");

endmodule

[hdl/swas_ram.sv]
module swas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/swas_outreg.sv]
module swas_outreg (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  swas_pkg::result_t push_data,
  input  logic              stall,
  output logic              valid,
  output swas_pkg::result_t data,
  output logic              free
);

  import swas_pkg::*;

  assign free = !valid || !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (push) begin
      valid <= 1'b1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data <= push_data;
    end
  end

endmodule

[hdl/swas_ctrl.sv]
module swas_ctrl #(
  parameter int WINDOW_SLOTS = swas_pkg::WINDOW_SLOTS_DEF,
  parameter int MAX_PAYLOAD  = swas_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       cfg_valid,
  input  logic [swas_pkg::LEN_W-1:0]                 cfg_data,
  input  logic                                       item_valid,
  input  swas_pkg::item_t                            item,
  output logic                                       item_stall,
  input  logic                                       out_free,
  output logic                                       push,
  output swas_pkg::result_t                          push_data,
  output swas_pkg::status_t                          status,
  output logic                                       store_we,
  output logic [$clog2(WINDOW_SLOTS*MAX_PAYLOAD)-1:0] store_waddr,
  output logic [7:0]                                 store_wdata,
  output logic                                       store_re,
  output logic [$clog2(WINDOW_SLOTS*MAX_PAYLOAD)-1:0] store_raddr,
  input  logic [7:0]                                 store_rdata,
  output logic                                       meta_we,
  output logic [$clog2(WINDOW_SLOTS)-1:0]            meta_waddr,
  output swas_pkg::meta_t                            meta_wdata,
  output logic                                       meta_re,
  output logic [$clog2(WINDOW_SLOTS)-1:0]            meta_raddr,
  input  swas_pkg::meta_t                            meta_rdata
);

  import swas_pkg::*;

  localparam int SLOT_W = $clog2(WINDOW_SLOTS);
  localparam int OUTS_W = $clog2(WINDOW_SLOTS + 1);
  localparam int ADDR_W = $clog2(WINDOW_SLOTS * MAX_PAYLOAD);

  state_t              state, state_next;
  logic [SLOT_W-1:0]   first_slot, first_slot_next;
  logic [SLOT_W-1:0]   next_slot, next_slot_next;
  logic [OUTS_W-1:0]   outstanding, outstanding_next;
  logic [SEQ_W-1:0]    next_ack, next_ack_next;
  logic [SEQ_W-1:0]    next_seq, next_seq_next;
  logic [LEN_W-1:0]    fill_count, fill_count_next;
  logic [LEN_W-1:0]    payload_length;
  logic [SLOT_W-1:0]   emit_slot, emit_slot_next;
  logic [SEQ_W-1:0]    emit_seq, emit_seq_next;
  logic [LEN_W-1:0]    emit_len, emit_len_next;
  kind_t               emit_kind, emit_kind_next;
  logic [HDR_IDX_W-1:0] cnt, cnt_next;
  logic [LEN_W-1:0]    idx, idx_next;
  logic [SEQ_W-1:0]    ack_q, ack_q_next;

  logic [LEN_W-1:0]    eff_len;
  logic [LEN_W-1:0]    fill_clamp;
  logic [LEN_W-1:0]    fill_inc;
  logic [LEN_W-1:0]    close_len;
  logic                window_full;
  logic                accept;
  logic                do_close;
  logic [SLOT_W-1:0]   first_inc;
  logic [SLOT_W-1:0]   next_inc;
  logic [ADDR_W-1:0]   emit_base;
  logic [7:0]          hdr_byte;

  assign window_full = (outstanding == OUTS_W'(WINDOW_SLOTS));
  assign item_stall  = (state != ST_IDLE) || !out_free;
  assign accept      = item_valid && !item_stall;
  assign status      = '{busy: (state != ST_IDLE), window_full: window_full};

  assign first_inc = (first_slot == SLOT_W'(WINDOW_SLOTS - 1)) ? '0 : first_slot + 1'b1;
  assign next_inc  = (next_slot == SLOT_W'(WINDOW_SLOTS - 1)) ? '0 : next_slot + 1'b1;
  assign emit_base = ADDR_W'(emit_slot) * ADDR_W'(MAX_PAYLOAD);

  always_comb begin
    if (payload_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (payload_length > LEN_W'(MAX_PAYLOAD)) begin
      eff_len = LEN_W'(MAX_PAYLOAD);
    end else begin
      eff_len = payload_length;
    end
  end

  assign fill_clamp = (fill_count >= LEN_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD - 1) : fill_count;
  assign fill_inc   = fill_clamp + 1'b1;

  always_comb begin
    case (cnt)
      3'd0:    hdr_byte = emit_seq[31:24];
      3'd1:    hdr_byte = emit_seq[23:16];
      3'd2:    hdr_byte = emit_seq[15:8];
      3'd3:    hdr_byte = emit_seq[7:0];
      3'd4:    hdr_byte = SYNC_FF;
      3'd5:    hdr_byte = SYNC_FF;
      default: hdr_byte = SYNC_55;
    endcase
  end

  always_comb begin
    state_next       = state;
    first_slot_next  = first_slot;
    next_slot_next   = next_slot;
    outstanding_next = outstanding;
    next_ack_next    = next_ack;
    next_seq_next    = next_seq;
    fill_count_next  = fill_count;
    emit_slot_next   = emit_slot;
    emit_seq_next    = emit_seq;
    emit_len_next    = emit_len;
    emit_kind_next   = emit_kind;
    cnt_next         = cnt;
    idx_next         = idx;
    ack_q_next       = ack_q;

    do_close  = 1'b0;
    close_len = fill_count;

    push        = 1'b0;
    push_data   = '{out_byte: 8'h00, out_last: 1'b0, out_kind: KIND_NEW};
    store_we    = 1'b0;
    store_waddr = ADDR_W'(next_slot) * ADDR_W'(MAX_PAYLOAD) + ADDR_W'(fill_clamp);
    store_wdata = item.data_byte;
    store_re    = 1'b0;
    store_raddr = emit_base;
    meta_we     = 1'b0;
    meta_waddr  = next_slot;
    meta_wdata  = '{seq: next_seq, len: close_len};
    meta_re     = 1'b0;
    meta_raddr  = first_slot;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (item.op)
            OP_DATA: begin
              if (window_full) begin
                push      = 1'b1;
                push_data = '{out_byte: 8'h00, out_last: 1'b1, out_kind: KIND_REFUSED};
              end else begin
                store_we = 1'b1;
                if (fill_inc >= eff_len) begin
                  do_close  = 1'b1;
                  close_len = fill_inc;
                end else begin
                  fill_count_next = fill_inc;
                end
              end
            end
            OP_FLUSH: begin
              do_close = (fill_count != '0) && !window_full;
            end
            default: begin
              if (item.op == OP_ACK && !item.ack_is_nak && item.ack_number >= next_ack) begin
                // release acknowledged segments oldest first
                if (outstanding != '0) begin
                  ack_q_next = item.ack_number;
                  meta_re    = 1'b1;
                  state_next = ST_SLIDE;
                end
              end else if (outstanding != '0) begin
                meta_re        = 1'b1;
                emit_slot_next = first_slot;
                emit_kind_next = KIND_RETX;
                state_next     = ST_META;
              end
            end
          endcase

          if (do_close) begin
            meta_we          = 1'b1;
            meta_wdata       = '{seq: next_seq, len: close_len};
            emit_slot_next   = next_slot;
            emit_seq_next    = next_seq;
            emit_len_next    = close_len;
            emit_kind_next   = KIND_NEW;
            cnt_next         = '0;
            next_seq_next    = next_seq + SEQ_W'(HDR_BYTES) + SEQ_W'(close_len);
            fill_count_next  = '0;
            next_slot_next   = next_inc;
            outstanding_next = outstanding + 1'b1;
            state_next       = ST_HDR;
          end
        end
      end

      ST_META: begin
        emit_seq_next = meta_rdata.seq;
        emit_len_next = meta_rdata.len;
        cnt_next      = '0;
        state_next    = ST_HDR;
      end

      ST_HDR: begin
        if (out_free) begin
          push      = 1'b1;
          push_data = '{out_byte: hdr_byte,
                        out_last: (cnt == HDR_IDX_W'(HDR_BYTES - 1)) && (emit_len == '0),
                        out_kind: emit_kind};
          if (cnt == HDR_IDX_W'(HDR_BYTES - 1)) begin
            if (emit_len == '0) begin
              state_next = ST_IDLE;
            end else begin
              // fetch the first payload byte while the last header byte goes out
              store_re    = 1'b1;
              store_raddr = emit_base;
              idx_next    = '0;
              state_next  = ST_PAY;
            end
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end

      ST_PAY: begin
        if (out_free) begin
          push      = 1'b1;
          push_data = '{out_byte: store_rdata,
                        out_last: (idx == emit_len - 1'b1),
                        out_kind: emit_kind};
          if (idx == emit_len - 1'b1) begin
            state_next = ST_IDLE;
          end else begin
            store_re    = 1'b1;
            store_raddr = emit_base + ADDR_W'(idx) + 1'b1;
            idx_next    = idx + 1'b1;
          end
        end
      end

      ST_SLIDE: begin
        if (ack_q < meta_rdata.seq) begin
          state_next = ST_IDLE;
        end else begin
          next_ack_next    = meta_rdata.seq + SEQ_W'(HDR_BYTES) + SEQ_W'(meta_rdata.len);
          first_slot_next  = first_inc;
          outstanding_next = outstanding - 1'b1;
          if (outstanding == OUTS_W'(1)) begin
            state_next = ST_IDLE;
          end else begin
            meta_re    = 1'b1;
            meta_raddr = first_inc;
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      first_slot     <= '0;
      next_slot      <= '0;
      outstanding    <= '0;
      next_ack       <= '0;
      next_seq       <= '0;
      fill_count     <= '0;
      payload_length <= PAYLOAD_LENGTH_RST;
    end else begin
      state       <= state_next;
      first_slot  <= first_slot_next;
      next_slot   <= next_slot_next;
      outstanding <= outstanding_next;
      next_ack    <= next_ack_next;
      next_seq    <= next_seq_next;
      fill_count  <= fill_count_next;
      if (cfg_valid) begin
        payload_length <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    emit_slot <= emit_slot_next;
    emit_seq  <= emit_seq_next;
    emit_len  <= emit_len_next;
    emit_kind <= emit_kind_next;
    cnt       <= cnt_next;
    idx       <= idx_next;
    ack_q     <= ack_q_next;
  end

endmodule

[tb/sv/sliding_window_arq_sender_top_tb.sv]
`timescale 1ns / 100ps

module sliding_window_arq_sender_top_tb;
  import swas_pkg::*;

  localparam int SLOTS       = WINDOW_SLOTS_DEF;
  localparam int PAY_MAX     = MAX_PAYLOAD_DEF;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 20;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;

  class arq_scoreboard;
    logic [7:0]       seg_bytes [SLOTS*PAY_MAX];
    logic [LEN_W-1:0] seg_len [SLOTS];
    logic [SEQ_W-1:0] seg_seq [SLOTS];
    int               first_slot;
    int               next_slot;
    int               in_flight;
    logic [SEQ_W-1:0] next_ack;
    logic [SEQ_W-1:0] next_seq;
    int               fill;
    logic [LEN_W-1:0] length_reg;
    result_t          expected [$];
    int               errors;

    function new();
      for (int i = 0; i < SLOTS*PAY_MAX; i++) seg_bytes[i] = 8'h00;
      for (int i = 0; i < SLOTS; i++) begin
        seg_len[i] = '0;
        seg_seq[i] = '0;
      end
      first_slot = 0;
      next_slot  = 0;
      in_flight  = 0;
      next_ack   = '0;
      next_seq   = '0;
      fill       = 0;
      length_reg = PAYLOAD_LENGTH_RST;
      errors     = 0;
    endfunction

    function void report_mismatch(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endfunction

    function int eff_len();
      if (length_reg == 0) return 1;
      if (length_reg > PAY_MAX) return PAY_MAX;
      return int'(length_reg);
    endfunction

    function void push_result(logic [7:0] b, logic last, kind_t kind);
      expected.push_back(result_t'{out_byte: b, out_last: last, out_kind: kind});
    endfunction

    function void emit_segment(int slot, kind_t kind);
      int               len;
      logic [SEQ_W-1:0] sq;
      logic [7:0]       hdr [HDR_BYTES];
      len = int'(seg_len[slot]);
      if (len > PAY_MAX) len = PAY_MAX;
      sq = seg_seq[slot];
      hdr[0] = sq[31:24];
      hdr[1] = sq[23:16];
      hdr[2] = sq[15:8];
      hdr[3] = sq[7:0];
      hdr[4] = SYNC_FF;
      hdr[5] = SYNC_FF;
      hdr[6] = SYNC_55;
      hdr[7] = SYNC_55;
      for (int i = 0; i < HDR_BYTES; i++)
        push_result(hdr[i], (len == 0 && i == HDR_BYTES - 1), kind);
      for (int i = 0; i < len; i++)
        push_result(seg_bytes[slot*PAY_MAX + i], (i + 1 == len), kind);
    endfunction

    function void close_segment();
      int s;
      s = next_slot;
      seg_len[s] = LEN_W'(fill);
      seg_seq[s] = next_seq;
      next_seq   = next_seq + SEQ_W'(HDR_BYTES) + SEQ_W'(fill);
      fill       = 0;
      next_slot  = (s + 1) % SLOTS;
      in_flight++;
      emit_segment(s, KIND_NEW);
    endfunction

    // predict the results of one accepted transfer
    function void note_item(item_t it);
      case (it.op)
        OP_DATA: begin
          if (in_flight >= SLOTS) begin
            push_result(8'h00, 1'b1, KIND_REFUSED);
          end else begin
            if (fill >= PAY_MAX) fill = PAY_MAX - 1;
            seg_bytes[next_slot*PAY_MAX + fill] = it.data_byte;
            fill++;
            if (fill >= eff_len()) close_segment();
          end
        end
        OP_FLUSH: begin
          if (fill != 0 && in_flight < SLOTS) close_segment();
        end
        default: begin
          if (it.op == OP_ACK && !it.ack_is_nak && it.ack_number >= next_ack) begin
            // slide past every segment covered by the cumulative ack
            while (in_flight > 0 && it.ack_number >= seg_seq[first_slot]) begin
              next_ack = seg_seq[first_slot] + SEQ_W'(HDR_BYTES) +
                         SEQ_W'(seg_len[first_slot]);
              first_slot = (first_slot + 1) % SLOTS;
              in_flight--;
            end
          end else if (in_flight != 0) begin
            emit_segment(first_slot, KIND_RETX);
          end
        end
      endcase
    endfunction

    function void check_result(result_t r);
      result_t e;
      if (expected.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte %02h last %0d kind %0d",
                                  r.out_byte, r.out_last, r.out_kind));
      end else begin
        e = expected.pop_front();
        if (r.out_byte !== e.out_byte)
          report_mismatch($sformatf("out_byte %02h, predicted %02h", r.out_byte, e.out_byte));
        if (r.out_last !== e.out_last)
          report_mismatch($sformatf("out_last %0d, predicted %0d", r.out_last, e.out_last));
        if (r.out_kind !== e.out_kind)
          report_mismatch($sformatf("out_kind %0d, predicted %0d", r.out_kind, e.out_kind));
      end
    endfunction

    // mostly acks that land on outstanding segments, some stale, some arbitrary
    function logic [SEQ_W-1:0] pick_ack();
      int               r;
      int               k;
      logic [SEQ_W-1:0] a;
      r = $urandom_range(0, 9);
      a = $urandom;
      if (in_flight > 0 && r < 6) begin
        k = $urandom_range(0, in_flight - 1);
        a = seg_seq[(first_slot + k) % SLOTS] + SEQ_W'($urandom_range(0, 3));
      end else if (r < 8 && next_ack >= 4) begin
        a = next_ack - SEQ_W'($urandom_range(1, 4));
      end else if (r == 8) begin
        a = next_ack;
      end
      return a;
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [LEN_W-1:0] cfg_data;
  logic             item_valid;
  logic             item_stall;
  item_t            item;
  logic             result_valid;
  logic             result_stall;
  result_t          result;

  arq_scoreboard sb = new();
  bit            no_idle;
  bit            hold_req;
  bit            hold_done;
  int unsigned   cycles = 0;

  sliding_window_arq_sender_top dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("sliding_window_arq_sender_top regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result);
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic item_t mk_item(op_t op, logic [7:0] d, logic [31:0] a, logic n);
    item_t it;
    it.op         = op;
    it.data_byte  = d;
    it.ack_number = a;
    it.ack_is_nak = n;
    return it;
  endfunction

  function automatic item_t make_item();
    item_t it;
    int    r;
    it.op         = OP_DATA;
    it.data_byte  = 8'($urandom_range(0, 255));
    it.ack_number = $urandom;
    it.ack_is_nak = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (r < 62) begin
      it.op = OP_DATA;
    end else if (r < 70) begin
      it.op = OP_FLUSH;
    end else if (r < 92) begin
      it.op         = OP_ACK;
      it.ack_is_nak = ($urandom_range(0, 9) == 0);
      it.ack_number = sb.pick_ack();
    end else begin
      it.op = OP_TIMEOUT;
    end
    return it;
  endfunction

  task automatic send_item(input item_t it);
    int gap;
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.note_item(it);
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // write only once every predicted byte is out and the block has settled
  task automatic write_length(input logic [LEN_W-1:0] v);
    item_valid <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.length_reg = v;
    cfg_valid <= 1'b0;
  endtask

  initial begin : receiver
    int run_left;
    run_left     = 0;
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (run_left > 0) begin
        run_left--;
        result_stall <= 1'b1;
      end else if (hold_req && !hold_done) begin
        // long hold-off: let the block back up into its input
        hold_done = 1'b1;
        run_left  = HOLD_CYCLES - 1;
        result_stall <= 1'b1;
      end else begin
        run_left = no_idle ? 0 : pick_gap();
        if (run_left > 0) begin
          run_left--;
          result_stall <= 1'b1;
        end else begin
          result_stall <= 1'b0;
        end
      end
    end
  end

  initial begin : stimulus
    logic [LEN_W-1:0] len;
    int               count;
    rst        = 1'b1;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    item_valid = 1'b0;
    item       = '0;
    no_idle    = 1'b0;
    hold_req   = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty window and empty segment cases first
    send_item(mk_item(OP_FLUSH,   8'h00, 32'h0000_0000, 1'b0));
    send_item(mk_item(OP_TIMEOUT, 8'h00, 32'h0000_0000, 1'b0));
    send_item(mk_item(OP_ACK,     8'h00, 32'h0000_0000, 1'b1));
    send_item(mk_item(OP_ACK,     8'h00, 32'h0000_0000, 1'b0));
    send_item(mk_item(OP_DATA,    8'h00, 32'h0000_0000, 1'b0));
    send_item(mk_item(OP_DATA,    8'hFF, 32'hFFFF_FFFF, 1'b1));
    send_item(mk_item(OP_FLUSH,   8'h00, 32'h0000_0000, 1'b0));
    send_item(mk_item(OP_DATA,    8'hA5, 32'h0000_0000, 1'b0));
    send_item(mk_item(OP_FLUSH,   8'h00, 32'h0000_0000, 1'b0));
    // release the first segment, then stale ack, timeout and NAK resend the second
    send_item(mk_item(OP_ACK,     8'h00, 32'h0000_0000, 1'b0));
    send_item(mk_item(OP_ACK,     8'h00, 32'h0000_0003, 1'b0));
    send_item(mk_item(OP_TIMEOUT, 8'h00, 32'h0000_0000, 1'b0));
    send_item(mk_item(OP_ACK,     8'h00, 32'hFFFF_FFFF, 1'b1));
    send_item(mk_item(OP_ACK,     8'h00, 32'hFFFF_FFFF, 1'b0));

    // one-byte segments fill the window, then a refused byte
    write_length(6'd1);
    repeat (SLOTS) send_item(mk_item(OP_DATA, 8'($urandom_range(0, 255)), 32'h0, 1'b0));
    send_item(mk_item(OP_DATA,    8'hFF, 32'h0000_0000, 1'b0));
    send_item(mk_item(OP_FLUSH,   8'h00, 32'h0000_0000, 1'b0));
    send_item(mk_item(OP_TIMEOUT, 8'h00, 32'h0000_0000, 1'b0));

    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       begin len = 6'd0;  count = 30; end
        1:       begin len = 6'd63; count = 60; end
        2:       begin len = 6'd4;  count = 40; end
        3:       begin len = 6'd1;  count = 30; end
        4:       begin len = 6'd8;  count = 40; end
        5:       begin len = LEN_W'($urandom_range(2, 16)); count = 40; end
        6:       begin len = 6'd56; count = 30; end
        default: begin len = 6'd2;  count = 30; end
      endcase
      write_length(len);
      no_idle  = (p == 2);
      hold_req = (p == 4);
      repeat (count) send_item(make_item());
    end
    no_idle = 1'b0;

    item_valid <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (sb.errors == 0)
      $display("sliding_window_arq_sender_top regression: pass");
    else
      $display("sliding_window_arq_sender_top regression: fail");
    $finish;
  end

endmodule
